// ===== src/mandelbrot_tile_escape_count_defines.svh =====
// Assertion macros shared by the escape-count RTL.
`ifndef MANDELBROT_TILE_ESCAPE_COUNT_DEFINES_SVH
`define MANDELBROT_TILE_ESCAPE_COUNT_DEFINES_SVH

// Overlapping implication, checked on the clock edge of the using module.
`define MTEC_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("mtec: property failed");

// Non-overlapping implication, checked on the clock edge of the using module.
`define MTEC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("mtec: property failed");

`endif

// ===== src/mtec_pkg.sv =====
// Shared constants, types and helper functions of the escape-count pipeline.
package mtec_pkg;

  localparam int MAX_ITER  = 256;
  localparam int TILE_SIZE = 512;
  localparam int FRAC_BITS = 56;

  localparam int DATA_W    = 64;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int HALF_W    = DATA_W / 2;
  localparam int COL_W     = 9;
  localparam int OUT_W     = 9;
  localparam int ZOOM_W    = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = $clog2(MAX_ITER + 1);
  localparam int OUT_MAX   = (1 << OUT_W) - 1;

  localparam int ITER_LAT  = 5;
  localparam int COORD_LAT = 3;
  localparam int PIPE_LAT  = COORD_LAT + MAX_ITER * ITER_LAT + 1;

  localparam logic [PROD_W:0] ESC_LIMIT = (PROD_W + 1)'(1) << (2 * FRAC_BITS + 2);

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_RE = 2'd0,
    REG_CENTER_IM = 2'd1,
    REG_ZOOM      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                     vld;
    logic                     done;
    logic [CNT_W-1:0]         cnt;
    logic signed [DATA_W-1:0] r;
    logic signed [DATA_W-1:0] i;
    logic signed [DATA_W-1:0] cr;
    logic signed [DATA_W-1:0] ci;
  } iter_st_t;

  typedef struct packed {
    logic                     done;
    logic [CNT_W-1:0]         cnt;
    logic signed [DATA_W-1:0] cr;
    logic signed [DATA_W-1:0] ci;
  } iter_ctl_t;

  function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? SAT_MIN : SAT_MAX;
    end
    return s[DATA_W-1:0];
  endfunction

endpackage

// ===== src/mtec_iter.sv =====
// One iteration of z = z*z + c with escape test, cut into five register stages.
`include "mandelbrot_tile_escape_count_defines.svh"

module mtec_iter import mtec_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  iter_st_t st_i,
  output iter_st_t st_o
);

  logic [ITER_LAT-2:0] vld_r;

  iter_ctl_t   ctl_in;
  iter_ctl_t   ctl1_r, ctl2_r, ctl3_r, ctl4_r;
  logic [DATA_W-1:0] mag_re_nxt, mag_im_nxt, mag_re1_r, mag_im1_r;
  logic        neg1_r, neg2_r, neg3_r;

  logic [DATA_W-1:0] rr_ll_r, rr_lh_r, rr_hh_r;
  logic [DATA_W-1:0] ii_ll_r, ii_lh_r, ii_hh_r;
  logic [DATA_W-1:0] ri_ll_r, ri_lh_r, ri_hl_r, ri_hh_r;

  logic [PROD_W-1:0] sq_re_nxt, sq_im_nxt, cross_nxt;
  logic [PROD_W-1:0] sq_re3_r, sq_im3_r, cross3_r;

  logic [PROD_W:0]          mag_sum;
  logic signed [PROD_W:0]   diff, cross_s;
  logic                     esc_nxt, esc4_r;
  logic signed [DATA_W-1:0] re_nxt, im_nxt, re4_r, im4_r;

  logic     stop;
  iter_st_t st_nxt, st_o_r;

  always_comb begin
    ctl_in.done = st_i.done;
    ctl_in.cnt  = st_i.cnt;
    ctl_in.cr   = st_i.cr;
    ctl_in.ci   = st_i.ci;
    mag_re_nxt  = st_i.r[DATA_W-1] ? DATA_W'(-st_i.r) : DATA_W'(st_i.r);
    mag_im_nxt  = st_i.i[DATA_W-1] ? DATA_W'(-st_i.i) : DATA_W'(st_i.i);
  end

  always_comb begin
    sq_re_nxt = {rr_hh_r, {DATA_W{1'b0}}} + ({{DATA_W{1'b0}}, rr_lh_r} << (HALF_W + 1))
              + {{DATA_W{1'b0}}, rr_ll_r};
    sq_im_nxt = {ii_hh_r, {DATA_W{1'b0}}} + ({{DATA_W{1'b0}}, ii_lh_r} << (HALF_W + 1))
              + {{DATA_W{1'b0}}, ii_ll_r};
    cross_nxt = {ri_hh_r, {DATA_W{1'b0}}} + ({{DATA_W{1'b0}}, ri_lh_r} << HALF_W)
              + ({{DATA_W{1'b0}}, ri_hl_r} << HALF_W) + {{DATA_W{1'b0}}, ri_ll_r};
  end

  always_comb begin
    mag_sum = {1'b0, sq_re3_r} + {1'b0, sq_im3_r};
    esc_nxt = mag_sum > ESC_LIMIT;
    diff    = $signed({1'b0, sq_re3_r}) - $signed({1'b0, sq_im3_r});
    cross_s = neg3_r ? -$signed({1'b0, cross3_r}) : $signed({1'b0, cross3_r});
    re_nxt  = DATA_W'(diff >>> FRAC_BITS);
    im_nxt  = DATA_W'(cross_s >>> (FRAC_BITS - 1));
  end

  always_comb begin
    stop        = ctl4_r.done | esc4_r;
    st_nxt.vld  = vld_r[ITER_LAT-2];
    st_nxt.done = stop;
    st_nxt.cnt  = stop ? ctl4_r.cnt : CNT_W'(ctl4_r.cnt + 1'b1);
    st_nxt.r    = sat_add(re4_r, ctl4_r.cr);
    st_nxt.i    = sat_add(im4_r, ctl4_r.ci);
    st_nxt.cr   = ctl4_r.cr;
    st_nxt.ci   = ctl4_r.ci;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      st_o_r <= '0;
    end else begin
      vld_r  <= {vld_r[ITER_LAT-3:0], st_i.vld};
      st_o_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctl1_r    <= ctl_in;
    mag_re1_r <= mag_re_nxt;
    mag_im1_r <= mag_im_nxt;
    neg1_r    <= st_i.r[DATA_W-1] ^ st_i.i[DATA_W-1];

    ctl2_r  <= ctl1_r;
    neg2_r  <= neg1_r;
    rr_ll_r <= mag_re1_r[HALF_W-1:0] * mag_re1_r[HALF_W-1:0];
    rr_lh_r <= mag_re1_r[HALF_W-1:0] * mag_re1_r[DATA_W-1:HALF_W];
    rr_hh_r <= mag_re1_r[DATA_W-1:HALF_W] * mag_re1_r[DATA_W-1:HALF_W];
    ii_ll_r <= mag_im1_r[HALF_W-1:0] * mag_im1_r[HALF_W-1:0];
    ii_lh_r <= mag_im1_r[HALF_W-1:0] * mag_im1_r[DATA_W-1:HALF_W];
    ii_hh_r <= mag_im1_r[DATA_W-1:HALF_W] * mag_im1_r[DATA_W-1:HALF_W];
    ri_ll_r <= mag_re1_r[HALF_W-1:0] * mag_im1_r[HALF_W-1:0];
    ri_lh_r <= mag_re1_r[HALF_W-1:0] * mag_im1_r[DATA_W-1:HALF_W];
    ri_hl_r <= mag_re1_r[DATA_W-1:HALF_W] * mag_im1_r[HALF_W-1:0];
    ri_hh_r <= mag_re1_r[DATA_W-1:HALF_W] * mag_im1_r[DATA_W-1:HALF_W];

    ctl3_r   <= ctl2_r;
    neg3_r   <= neg2_r;
    sq_re3_r <= sq_re_nxt;
    sq_im3_r <= sq_im_nxt;
    cross3_r <= cross_nxt;

    ctl4_r <= ctl3_r;
    esc4_r <= esc_nxt;
    re4_r  <= re_nxt;
    im4_r  <= im_nxt;
  end

  assign st_o = st_o_r;

  `MTEC_ASSERT(a_vld_lat, st_i.vld, ##ITER_LAT st_o.vld)
  `MTEC_ASSERT_NEXT(a_done_hold, st_i.vld && st_i.done,
    ##(ITER_LAT - 1) (st_o.done && st_o.cnt == $past(st_i.cnt, ITER_LAT)))
  `MTEC_ASSERT(a_cnt_step, st_i.vld && !st_i.done,
    ##ITER_LAT (st_o.done ? st_o.cnt == $past(st_i.cnt, ITER_LAT)
                          : st_o.cnt == $past(st_i.cnt, ITER_LAT) + 1'b1))

endmodule

// ===== src/mandelbrot_tile_escape_count.sv =====
// Top level of the Mandelbrot tile escape-count pipeline.
// An accepted item passes the coordinate stages, MAX_ITER iteration units and the output register to its result.
// Throughput: one item per cycle while busy is low; every iteration has its own five-stage unit.
// busy is high only during reset and the cycle after; results cannot be held off.
// Reset clears the configuration registers and all valid bits.
`include "mandelbrot_tile_escape_count_defines.svh"

module mandelbrot_tile_escape_count import mtec_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [COL_W-1:0]     in_column,
  input  logic [COL_W-1:0]     in_row,
  output logic                 out_valid,
  output logic [OUT_W-1:0]     out_escape_count,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  localparam int D_W  = (COL_W + 2 > $clog2(TILE_SIZE) + 1) ? COL_W + 2
                                                            : $clog2(TILE_SIZE) + 1;
  localparam int TW   = D_W + DATA_W - 1;
  localparam int SH_W = $clog2(DATA_W - FRAC_BITS + (1 << ZOOM_W));
  localparam int CMP_W = (CNT_W > OUT_W) ? CNT_W : OUT_W;

  function automatic logic signed [DATA_W-1:0] pixel_offset(input logic signed [D_W-1:0] d,
                                                            input logic [ZOOM_W-1:0] zm);
    logic signed [TW-1:0] t;
    logic signed [TW-1:0] w;
    logic [SH_W-1:0]      sh;
    t  = $signed({d, {(DATA_W - 1){1'b0}}});
    sh = SH_W'(DATA_W - FRAC_BITS) + SH_W'(zm);
    w  = t >>> sh;
    if (w[TW-1:DATA_W-1] == {(TW - DATA_W + 1){w[DATA_W-1]}}) begin
      return w[DATA_W-1:0];
    end
    return w[TW-1] ? SAT_MIN : SAT_MAX;
  endfunction

  logic                     busy_r;
  logic signed [DATA_W-1:0] center_re_r, center_im_r;
  logic [ZOOM_W-1:0]        zoom_r;

  logic                     accept;
  logic signed [D_W-1:0]    d_re_nxt, d_im_nxt, d_re_r, d_im_r;
  logic                     c1_vld_r, c2_vld_r, s0_vld_r;
  logic signed [DATA_W-1:0] off_re_r, off_im_r, cr0_r, ci0_r;

  iter_st_t it_st [0:MAX_ITER];

  logic [CMP_W-1:0] cnt_ext;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_cnt_r, out_cnt_nxt;

  assign accept = start & ~busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      center_re_r <= '0;
      center_im_r <= '0;
      zoom_r      <= '0;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_CENTER_RE: center_re_r <= cfg_wdata;
          REG_CENTER_IM: center_im_r <= cfg_wdata;
          REG_ZOOM:      zoom_r      <= cfg_wdata[ZOOM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    d_re_nxt = $signed({{(D_W - COL_W - 1){1'b0}}, in_column, 1'b0})
             - $signed(D_W'(TILE_SIZE - 1));
    d_im_nxt = $signed({{(D_W - COL_W - 1){1'b0}}, in_row, 1'b0})
             - $signed(D_W'(TILE_SIZE - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_vld_r    <= 1'b0;
      c2_vld_r    <= 1'b0;
      s0_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      c1_vld_r    <= accept;
      c2_vld_r    <= c1_vld_r;
      s0_vld_r    <= c2_vld_r;
      out_valid_r <= it_st[MAX_ITER].vld;
    end
  end

  always_ff @(posedge clk) begin
    d_re_r    <= d_re_nxt;
    d_im_r    <= d_im_nxt;
    off_re_r  <= pixel_offset(d_re_r, zoom_r);
    off_im_r  <= pixel_offset(d_im_r, zoom_r);
    cr0_r     <= sat_add(center_re_r, off_re_r);
    ci0_r     <= sat_add(center_im_r, off_im_r);
    out_cnt_r <= out_cnt_nxt;
  end

  assign it_st[0] = '{vld: s0_vld_r, done: 1'b0, cnt: '0, r: '0, i: '0,
                      cr: cr0_r, ci: ci0_r};

  for (genvar k = 0; k < MAX_ITER; k++) begin : g_iter
    mtec_iter u_iter (
      .clk   (clk),
      .rst_n (rst_n),
      .st_i  (it_st[k]),
      .st_o  (it_st[k+1])
    );
  end

  always_comb begin
    cnt_ext     = CMP_W'(it_st[MAX_ITER].cnt);
    out_cnt_nxt = (cnt_ext > CMP_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : OUT_W'(cnt_ext);
  end

  assign busy             = busy_r;
  assign out_valid        = out_valid_r;
  assign out_escape_count = out_cnt_r;

  `MTEC_ASSERT(a_out_lat, out_valid, $past(start && !busy, PIPE_LAT))
  `MTEC_ASSERT(a_entry_lat, start && !busy, ##COORD_LAT it_st[0].vld)
  `MTEC_ASSERT(a_busy_idle, $past(rst_n), !busy)

endmodule

// ===== tb/sv/mandelbrot_tile_escape_count_tb.sv =====
// Self-checking testbench for the Mandelbrot tile escape-count pipeline.
`timescale 1ns / 100ps

module mandelbrot_tile_escape_count_tb import mtec_pkg::*; ;

  localparam int WIDE_W = 2 * DATA_W + 2;
  localparam logic signed [WIDE_W-1:0] ESC_BOUND =
    {{(WIDE_W - 1){1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

  class escape_scoreboard;
    logic signed [DATA_W-1:0] ctr_re;
    logic signed [DATA_W-1:0] ctr_im;
    logic [ZOOM_W-1:0]        zoom;
    logic [OUT_W-1:0]         expected_counts[$];
    int                       errors;

    function new();
      ctr_re = '0;
      ctr_im = '0;
      zoom   = '0;
      errors = 0;
    endfunction

    static function logic signed [DATA_W-1:0] clamp(logic signed [WIDE_W-1:0] x);
      if (&x[WIDE_W-1:DATA_W-1] || !(|x[WIDE_W-1:DATA_W-1])) begin
        return x[DATA_W-1:0];
      end
      return x[WIDE_W-1] ? SAT_MIN : SAT_MAX;
    endfunction

    function logic signed [DATA_W-1:0] coord(logic signed [DATA_W-1:0] ctr,
                                             logic [COL_W-1:0] idx);
      logic signed [WIDE_W-1:0] span;
      logic signed [WIDE_W-1:0] offs;
      int sh;
      span = 2 * $signed({1'b0, idx}) - (TILE_SIZE - 1);
      sh = FRAC_BITS - int'(zoom) - 1;
      if (sh >= 0) begin
        offs = span <<< sh;
      end else begin
        offs = span >>> (-sh);
      end
      offs = clamp(offs);
      return clamp(offs + ctr);
    endfunction

    function int escape_steps(logic signed [DATA_W-1:0] c_re,
                              logic signed [DATA_W-1:0] c_im);
      logic signed [WIDE_W-1:0] zr;
      logic signed [WIDE_W-1:0] zi;
      logic signed [WIDE_W-1:0] sq_re;
      logic signed [WIDE_W-1:0] sq_im;
      logic signed [WIDE_W-1:0] zrzi;
      int n;
      zr = '0;
      zi = '0;
      n = 0;
      while (n < MAX_ITER) begin
        sq_re = zr * zr;
        sq_im = zi * zi;
        if (sq_re + sq_im > ESC_BOUND) break;
        zrzi = zr * zi;
        zr = clamp(((sq_re - sq_im) >>> FRAC_BITS) + c_re);
        zi = clamp((zrzi >>> (FRAC_BITS - 1)) + c_im);
        n++;
      end
      return n;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      unique case (cfg_reg_t'(idx))
        REG_CENTER_RE: ctr_re = val;
        REG_CENTER_IM: ctr_im = val;
        REG_ZOOM:      zoom = val[ZOOM_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [COL_W-1:0] col, logic [COL_W-1:0] row);
      int n;
      n = escape_steps(coord(ctr_re, col), coord(ctr_im, row));
      if (n > OUT_MAX) n = OUT_MAX;
      expected_counts.push_back(OUT_W'(n));
    endfunction

    function void check_count(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (expected_counts.size() == 0) begin
        $display("%0t: escape count mismatch, expected none, actual %0d", $time, got);
        errors++;
      end else begin
        want = expected_counts.pop_front();
        if (got !== want) begin
          $display("%0t: escape count mismatch, expected %0d, actual %0d", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_counts.size();
    endfunction
  endclass

  localparam int STALL_LIMIT = 4 * PIPE_LAT + 1000;
  localparam logic signed [DATA_W-1:0] RE_MAIN  = 64'shFF40_0000_0000_0000;
  localparam logic signed [DATA_W-1:0] RE_EDGE  = 64'shFF40_EB85_1EB8_51EC;
  localparam logic signed [DATA_W-1:0] IM_EDGE  = 64'sh001C_ED91_6872_B021;
  localparam logic signed [DATA_W-1:0] RE_CUSP  = 64'sh0040_0000_0000_0000;
  localparam logic signed [DATA_W-1:0] RE_MINUS = 64'shFF00_0000_0000_0000;
  localparam logic signed [DATA_W-1:0] IM_TENTH = 64'sh0019_9999_9999_999A;
  localparam logic [COL_W-1:0] IDX_TOP = '1;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [COL_W-1:0]     in_column;
  logic [COL_W-1:0]     in_row;
  logic                 out_valid;
  logic [OUT_W-1:0]     out_escape_count;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_wdata;

  escape_scoreboard sb;
  int stall_cycles = 0;

  mandelbrot_tile_escape_count u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_column        (in_column),
    .in_row           (in_row),
    .out_valid        (out_valid),
    .out_escape_count (out_escape_count),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && cfg_we) sb.set_register(cfg_index, cfg_wdata);
    if (start && !busy) sb.note_pixel(in_column, in_row);
    if (out_valid) sb.check_count(out_escape_count);
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(90, 20);
  endfunction

  function automatic logic [COL_W-1:0] pick_index();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? IDX_TOP : '0;
    return COL_W'($urandom_range(int'(IDX_TOP)));
  endfunction

  function automatic logic signed [DATA_W-1:0] near_origin();
    return $signed({$urandom, $urandom}) >>> 6;
  endfunction

  task automatic send_pixel(input logic [COL_W-1:0] col, input logic [COL_W-1:0] row,
                            input int gap);
    start     <= 1'b1;
    in_column <= col;
    in_row    <= row;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic load_view(input logic signed [DATA_W-1:0] re,
                           input logic signed [DATA_W-1:0] im,
                           input logic [ZOOM_W-1:0] zm);
    wait_drained();
    while (busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CENTER_RE;
    cfg_wdata <= re;
    @(posedge clk);
    cfg_index <= REG_CENTER_IM;
    cfg_wdata <= im;
    @(posedge clk);
    cfg_index <= REG_ZOOM;
    cfg_wdata <= DATA_W'(zm);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic pixel_burst(input int count, input bit dense);
    int k;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] row;
    for (k = 0; k < count; k++) begin
      col = pick_index();
      row = pick_index();
      send_pixel(col, row, dense ? 0 : pick_gap());
    end
  endtask

  initial begin
    int p;
    sb        = new();
    rst_n     = 1'b0;
    start     = 1'b0;
    in_column = '0;
    in_row    = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_CENTER_RE;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_pixel('0, '0, pick_gap());
    send_pixel(IDX_TOP, IDX_TOP, pick_gap());
    send_pixel(COL_W'(255), COL_W'(255), pick_gap());
    send_pixel(COL_W'(256), COL_W'(256), pick_gap());
    send_pixel('0, IDX_TOP, pick_gap());

    load_view(SAT_MAX, SAT_MAX, '0);
    send_pixel(IDX_TOP, IDX_TOP, pick_gap());
    send_pixel('0, '0, pick_gap());
    load_view(SAT_MIN, SAT_MIN, '0);
    send_pixel('0, '0, pick_gap());
    send_pixel(IDX_TOP, IDX_TOP, pick_gap());

    load_view(RE_MAIN, '0, ZOOM_W'(8));
    send_pixel('0, '0, pick_gap());
    send_pixel(IDX_TOP, '0, pick_gap());
    send_pixel(COL_W'(255), COL_W'(255), pick_gap());
    send_pixel(COL_W'(256), COL_W'(256), pick_gap());
    send_pixel(COL_W'(255), COL_W'(256), pick_gap());
    send_pixel(COL_W'(100), COL_W'(300), pick_gap());
    send_pixel(IDX_TOP, IDX_TOP, pick_gap());

    load_view(RE_CUSP, '0, ZOOM_W'(56));
    send_pixel(COL_W'(255), COL_W'(255), pick_gap());
    send_pixel(COL_W'(256), COL_W'(256), pick_gap());
    send_pixel('0, IDX_TOP, pick_gap());

    load_view(RE_MINUS, '0, ZOOM_W'(63));
    send_pixel('0, '0, pick_gap());
    send_pixel(IDX_TOP, IDX_TOP, pick_gap());
    send_pixel(COL_W'(255), COL_W'(256), pick_gap());

    load_view(RE_MAIN, '0, ZOOM_W'(8));
    pixel_burst(150, 1'b0);
    wait_drained();
    pixel_burst(40, 1'b1);

    load_view(RE_EDGE, IM_EDGE, ZOOM_W'(12));
    pixel_burst(30, 1'b1);
    pixel_burst(70, 1'b0);

    for (p = 0; p < 8; p++) begin
      load_view(near_origin(), near_origin(), ZOOM_W'($urandom_range(63)));
      pixel_burst(30, p[0]);
    end

    load_view(RE_MAIN, IM_TENTH, ZOOM_W'(56));
    pixel_burst(30, 1'b0);
    load_view(RE_MAIN, IM_TENTH, ZOOM_W'(63));
    pixel_burst(30, 1'b0);
    load_view($signed({$urandom, $urandom}), $signed({$urandom, $urandom}),
              ZOOM_W'($urandom_range(63)));
    pixel_burst(20, 1'b0);
    load_view(SAT_MAX, SAT_MIN, ZOOM_W'(63));
    pixel_burst(20, 1'b1);
    load_view(SAT_MIN, SAT_MAX, ZOOM_W'(1));
    pixel_burst(20, 1'b0);

    wait_drained();
    repeat (PIPE_LAT + 16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/mtec_pkg.sv
src/mtec_iter.sv
src/mandelbrot_tile_escape_count.sv
tb/sv/mandelbrot_tile_escape_count_tb.sv
